// ===== rtl/kwc_pkg.sv =====
// kwc_pkg: shared types and constants for the kaiser window coefficient block
// no dependencies
`timescale 1ns / 1ps

package kwc_pkg;

  localparam int ALPHA_W = 16;
  localparam int HALF_W  = 11;
  localparam int INDEX_W = 10;
  localparam int COEF_W  = 17;

  localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
  localparam logic [15:0] ALPHA_MAX = 16'd32768;
  localparam logic [63:0] ONE_Q24   = 64'd1 << 24;
  localparam logic [16:0] COEF_ONE  = 17'd65536;

  // shared divider geometry
  localparam int DQ_W  = 80;
  localparam int DVS_W = 64;
  localparam int REM_W = 65;
  localparam logic [6:0] DIV_LAST_64 = 7'd63;
  localparam logic [6:0] DIV_LAST_80 = 7'd79;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_HALF  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_C,
    ST_MUL_Y0,
    ST_MUL_NN,
    ST_MUL_II,
    ST_MUL_P,
    ST_DIV_Y,
    ST_BES_INIT,
    ST_BES_HI,
    ST_BES_LO,
    ST_BES_DIV,
    ST_BES_ACC,
    ST_FIN_DIV,
    ST_DONE
  } kwc_state_t;

endpackage

// ===== rtl/kaiser_window_coefficient_top.sv =====
// kaiser_window_coefficient_top: half-window kaiser-bessel coefficient generator
// depends on kwc_pkg
`timescale 1ns / 1ps

// One transaction carries a coefficient index i and returns
// I0(pi*alpha*sqrt(1-(i/N)^2)) / I0(pi*alpha) as unsigned Q1.16, where N is
// half_size limited to MAX_HALF and alpha is Q4.12 limited to 8.0. I0 is the
// power series, one plus SERIES_TERMS terms, summed in Q40.24. All arithmetic
// runs through one 32x32 multiplier and one restoring divider (one quotient bit
// per cycle) under a small sequencer, so the block takes one item at a time and
// holds in_stall high until its result is in the output register. An in-range
// item with a nonzero index spends most of its time in the divide per series
// term. An index of zero or an out-of-range index goes straight to ST_DONE.
// The output register lets a new item be accepted while the last result
// waits on out_stall. Configuration (alpha at index 0, half_size at index 1)
// is for the user to write while idle; the block itself does not enforce it.

module kaiser_window_coefficient_top
  import kwc_pkg::*;
#(
  parameter int MAX_HALF     = 1024,
  parameter int SERIES_TERMS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [ALPHA_W-1:0]   cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [INDEX_W-1:0]   index,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COEF_W-1:0]    coefficient,
  output logic                 out_of_range
);

  // series term counter, k squared fits in twice its width
  localparam int K_W   = $clog2(SERIES_TERMS + 1);
  localparam int KSQ_W = 2 * K_W;

  kwc_state_t state, state_next;

  // configuration registers
  logic [ALPHA_W-1:0] alpha;
  logic [HALF_W-1:0]  half_size;

  // per-item working registers
  logic [INDEX_W-1:0] idx;
  logic [HALF_W-1:0]  n_eff;
  logic [31:0]        c_q24;
  logic [31:0]        y0;
  logic [21:0]        nn;
  logic [19:0]        ii;
  logic [31:0]        bes_y;
  logic [63:0]        term;
  logic [63:0]        part_hi;
  logic [63:0]        acc;
  logic [63:0]        den;
  logic [K_W-1:0]     k;
  logic [KSQ_W-1:0]   ksq;
  logic               pass;
  logic [COEF_W-1:0]  res_coef;
  logic               res_oor;
  logic [31:0]        y_num;
  logic [31:0]        bes_sel;

  // shared divider registers
  logic [DQ_W-1:0]    dq;
  logic [DVS_W-1:0]   dvs;
  logic [REM_W-1:0]   rem;
  logic [6:0]         div_cnt;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // divider step
  logic [REM_W-1:0] rem_sh;
  logic [REM_W:0]   diff;
  logic             q_bit;
  logic [DQ_W-1:0]  dq_step;
  logic [REM_W-1:0] rem_step;

  logic [15:0]        alpha_sat;
  logic [HALF_W-1:0]  n_sat;
  logic               in_accept;
  logic               out_free;
  logic               div_done;
  logic [63:0]        t_lo_sum;
  logic [63:0]        acc_sum;

  assign alpha_sat = (alpha > ALPHA_MAX) ? ALPHA_MAX : alpha;
  assign n_sat     = (17'(half_size) > 17'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_size;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // one restoring step: bring in the next dividend bit, try the subtract
  assign rem_sh   = {rem[REM_W-2:0], dq[DQ_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign q_bit    = !diff[REM_W];
  assign rem_step = q_bit ? diff[REM_W-1:0] : rem_sh;
  assign dq_step  = {dq[DQ_W-2:0], q_bit};

  assign t_lo_sum = part_hi + (mul_p >> 24);
  assign acc_sum  = acc + dq[63:0];

  // first pass uses y0 for the denominator, second pass the scaled y
  always_comb begin
    bes_sel = pass ? y_num : y0;
  end

  // next state
  always_comb begin
    state_next = state;
    div_done   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if ({1'b0, index} >= n_sat || index == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_MUL_C;
          end
        end
      end
      ST_MUL_C:    state_next = ST_MUL_Y0;
      ST_MUL_Y0:   state_next = ST_MUL_NN;
      ST_MUL_NN:   state_next = ST_MUL_II;
      ST_MUL_II:   state_next = ST_MUL_P;
      ST_MUL_P:    state_next = ST_DIV_Y;
      ST_DIV_Y: begin
        div_done = (div_cnt == DIV_LAST_64);
        if (div_done) state_next = ST_BES_INIT;
      end
      ST_BES_INIT: state_next = ST_BES_HI;
      ST_BES_HI:   state_next = ST_BES_LO;
      ST_BES_LO:   state_next = ST_BES_DIV;
      ST_BES_DIV: begin
        div_done = (div_cnt == DIV_LAST_64);
        if (div_done) state_next = ST_BES_ACC;
      end
      ST_BES_ACC: begin
        if (32'(k) != 32'(SERIES_TERMS)) begin
          state_next = ST_BES_HI;
        end else if (!pass) begin
          state_next = ST_BES_INIT;
        end else begin
          state_next = ST_FIN_DIV;
        end
      end
      ST_FIN_DIV: begin
        div_done = (div_cnt == DIV_LAST_80);
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select and handshake outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_MUL_C: begin
        mul_a = PI_Q30;
        mul_b = 32'(alpha_sat);
      end
      ST_MUL_Y0: begin
        mul_a = c_q24;
        mul_b = c_q24;
      end
      ST_MUL_NN: begin
        mul_a = 32'(n_eff);
        mul_b = 32'(n_eff);
      end
      ST_MUL_II: begin
        mul_a = 32'(idx);
        mul_b = 32'(idx);
      end
      ST_MUL_P: begin
        mul_a = y0;
        mul_b = 32'(nn - 22'(ii));
      end
      ST_BES_HI: begin
        mul_a = term[63:32];
        mul_b = bes_y;
      end
      ST_BES_LO: begin
        mul_a = term[31:0];
        mul_b = bes_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      alpha     <= 16'd8192;
      half_size <= 11'd64;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ALPHA: alpha     <= cfg_data;
          CFG_HALF:  half_size <= cfg_data[HALF_W-1:0];
          default:   ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          idx   <= index;
          n_eff <= n_sat;
          if ({1'b0, index} >= n_sat) begin
            res_coef <= '0;
            res_oor  <= 1'b1;
          end else begin
            // index zero is exactly 1.0
            res_coef <= COEF_ONE;
            res_oor  <= 1'b0;
          end
        end
      end
      ST_MUL_C:  c_q24 <= mul_p[50:19];
      ST_MUL_Y0: y0    <= mul_p[55:24];
      ST_MUL_NN: nn    <= mul_p[21:0];
      ST_MUL_II: ii    <= mul_p[19:0];
      ST_MUL_P: begin
        // y = y0 * (n^2 - i^2) / n^2
        dq      <= {mul_p, 16'd0};
        dvs     <= 64'(nn);
        rem     <= '0;
        div_cnt <= '0;
        pass    <= 1'b0;
      end
      ST_DIV_Y, ST_BES_DIV, ST_FIN_DIV: begin
        dq      <= dq_step;
        rem     <= rem_step;
        div_cnt <= div_cnt + 7'd1;
      end
      ST_BES_INIT: begin
        // first pass evaluates the denominator I0(pi*alpha)
        bes_y <= bes_sel;
        term  <= ONE_Q24;
        acc   <= ONE_Q24;
        k     <= K_W'(1);
        ksq   <= KSQ_W'(1);
      end
      ST_BES_HI: part_hi <= mul_p << 8;
      ST_BES_LO: begin
        dq      <= {t_lo_sum, 16'd0};
        dvs     <= 64'(ksq);
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_BES_ACC: begin
        term <= dq[63:0];
        acc  <= acc_sum;
        k    <= k + K_W'(1);
        // (k+1)^2 = k^2 + 2k + 1
        ksq  <= ksq + KSQ_W'({k, 1'b1});
        if (32'(k) == 32'(SERIES_TERMS)) begin
          if (!pass) begin
            den  <= acc_sum;
            pass <= 1'b1;
          end else begin
            dq      <= {acc_sum, 16'd0};
            dvs     <= den;
            rem     <= '0;
            div_cnt <= '0;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          coefficient  <= res_coef;
          out_of_range <= res_oor;
        end
      end
      default: ;
    endcase
    if (state == ST_FIN_DIV && div_done) begin
      res_coef <= (dq_step > DQ_W'(COEF_ONE)) ? COEF_ONE : dq_step[COEF_W-1:0];
      res_oor  <= 1'b0;
    end
  end

  // keep the quotient of the y divide for the second series pass
  always_ff @(posedge clk) begin
    if (state == ST_DIV_Y && div_done) begin
      y_num <= dq_step[31:0];
    end
  end

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for the kaiser window coefficient block
// depends on kwc_pkg and kaiser_window_coefficient_top
`timescale 1ns / 1ps

module testbench;
  import kwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic                 cfg_index;
  logic [ALPHA_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [INDEX_W-1:0]   index;
  logic                 out_valid;
  logic                 out_stall;
  logic [COEF_W-1:0]    coefficient;
  logic                 out_of_range;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              oor;
  } window_point_t;

  // expected results, oldest first
  window_point_t pending_points[$];

  // predictor copy of the two registers
  logic [ALPHA_W-1:0] shadow_alpha;
  logic [HALF_W-1:0]  shadow_half;

  int  fail_count;
  int  idle_cycles;
  bit  hold_request;
  bit  hold_active;

  kaiser_window_coefficient_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .index        (index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coefficient  (coefficient),
    .out_of_range (out_of_range)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // floor(a * b / 2^24) split in two halves, wraps like 64-bit hardware
  function automatic longint unsigned q24_mul(longint unsigned a, longint unsigned b);
    longint unsigned hi;
    longint unsigned lo;
    hi = a >> 32;
    lo = a & 64'hFFFF_FFFF;
    return ((hi * b) << 8) + ((lo * b) >> 24);
  endfunction

  // modified bessel I0 with y = x^2/4 in Q.24, fixed term count, Q40.24 out
  function automatic longint unsigned bessel_series(longint unsigned y);
    longint unsigned acc;
    longint unsigned term;
    acc  = ONE_Q24;
    term = ONE_Q24;
    for (longint unsigned k = 1; k <= 40; k++) begin
      term = q24_mul(term, y) / (k * k);
      acc  = acc + term;
    end
    return acc;
  endfunction

  function automatic window_point_t window_point(logic [INDEX_W-1:0] idx);
    window_point_t   p;
    longint unsigned n, a, i, c, y0, y, nn, num, den, q, r;
    n = shadow_half;
    a = shadow_alpha;
    i = idx;
    if (n > 1024) n = 1024;
    if (i >= n) begin
      p.coef = '0;
      p.oor  = 1'b1;
      return p;
    end
    if (a > ALPHA_MAX) a = ALPHA_MAX;
    c   = (longint'(PI_Q30) * a) >> 19;
    y0  = (c * c) >> 24;
    nn  = n * n;
    y   = (y0 * (nn - i * i)) / nn;
    den = bessel_series(y0 & 64'hFFFF_FFFF);
    num = bessel_series(y & 64'hFFFF_FFFF);
    q   = num / den;
    r   = num % den;
    for (int b = 0; b < 16; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    if (q > 65536) q = 65536;
    if (i == 0) q = 65536;
    p.coef = q[COEF_W-1:0];
    p.oor  = 1'b0;
    return p;
  endfunction

  // input side: predict each accepted transaction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_points.push_back(window_point(index));
  end

  // output side: compare each accepted transaction with the oldest prediction
  always @(posedge clk) begin
    window_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result: coefficient %0d out_of_range %0d",
               coefficient, out_of_range);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (coefficient !== want.coef) begin
          $error("coefficient: expected %0d actual %0d", want.coef, coefficient);
          fail_count++;
        end
        if (out_of_range !== want.oor) begin
          $error("out_of_range: expected %0d actual %0d", want.oor, out_of_range);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls: mostly none or short, a few long, plus one requested long hold
  initial begin
    int r;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        hold_active  = 1'b0;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(0, 30)) @(posedge clk);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(0, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 200)) @(posedge clk);
        end
      end
    end
  end

  task automatic write_register(logic reg_sel, logic [ALPHA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (reg_sel == CFG_ALPHA)
      shadow_alpha = value;
    else
      shadow_half = value[HALF_W-1:0];
    @(posedge clk);
  endtask

  // offer one index, with an optional random gap, and wait for acceptance
  task automatic send_index(logic [INDEX_W-1:0] idx, bit gaps);
    int g;
    g = 0;
    if (gaps) begin
      g = $urandom_range(0, 99);
      g = (g < 50) ? 0 : (g < 90) ? $urandom_range(1, 4) : $urandom_range(20, 150);
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    index    <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every prediction has been matched, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // random index biased so most transactions are cheap, many still in range
  function automatic logic [INDEX_W-1:0] pick_index();
    int r;
    int n;
    n = (shadow_half > 1024) ? 1024 : int'(shadow_half);
    r = $urandom_range(0, 99);
    if (r < 25 && n > 1)
      return INDEX_W'($urandom_range(1, n - 1));
    else if (r < 35)
      return '0;
    else if (r < 65 && n <= 1023)
      return INDEX_W'($urandom_range(n, 1023));
    else if (r < 72)
      return 10'h3FF;
    else
      return INDEX_W'($urandom_range(0, 1023));
  endfunction

  task automatic test_reset_defaults;
    // reset values alpha 2.0, N 64
    send_index(10'd0, 1'b0);
    send_index(10'd1, 1'b0);
    send_index(10'd63, 1'b0);
    send_index(10'd64, 1'b0);
    drain();
  endtask

  task automatic test_directed_extremes;
    // rectangular window: alpha zero
    write_register(CFG_ALPHA, 16'd0);
    write_register(CFG_HALF, 16'd8);
    send_index(10'd0, 1'b0);
    send_index(10'd5, 1'b0);
    send_index(10'd7, 1'b0);
    send_index(10'd8, 1'b0);
    drain();
    // alpha at 8.0 and above, which saturates; N at and above the limit
    write_register(CFG_ALPHA, 16'd32768);
    write_register(CFG_HALF, 16'd1024);
    send_index(10'd1023, 1'b0);
    send_index(10'd512, 1'b0);
    send_index(10'd0, 1'b0);
    drain();
    write_register(CFG_ALPHA, 16'hFFFF);
    write_register(CFG_HALF, 16'h07FF);
    send_index(10'd1023, 1'b0);
    send_index(10'd1, 1'b0);
    drain();
    // N of one: only index zero in range
    write_register(CFG_HALF, 16'd1);
    send_index(10'd0, 1'b0);
    send_index(10'd1, 1'b0);
    send_index(10'd1023, 1'b0);
    drain();
    // N zero: everything out of range
    write_register(CFG_HALF, 16'd0);
    send_index(10'd0, 1'b0);
    send_index(10'd1023, 1'b0);
    drain();
    write_register(CFG_ALPHA, 16'd1);
    write_register(CFG_HALF, 16'd2);
    send_index(10'd1, 1'b0);
    drain();
  endtask

  task automatic test_backpressure_fill;
    // long receiver hold while fast transactions keep coming
    write_register(CFG_ALPHA, 16'd12288);
    write_register(CFG_HALF, 16'd16);
    hold_request = 1'b1;
    wait (hold_active);
    for (int k = 0; k < 6; k++)
      send_index((k % 2) ? 10'd700 : 10'd0, 1'b0);
    send_index(10'd3, 1'b0);
    drain();
  endtask

  task automatic test_random_phases(int total);
    int per_phase;
    per_phase = total / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_ALPHA, 16'd8192);
          write_register(CFG_HALF, 16'd64);
        end
        1: begin
          write_register(CFG_ALPHA, 16'd32768);
          write_register(CFG_HALF, 16'd1024);
        end
        2: begin
          write_register(CFG_ALPHA, 16'd0);
          write_register(CFG_HALF, 16'd3);
        end
        3: begin
          write_register(CFG_ALPHA, 16'hFFFF);
          write_register(CFG_HALF, 16'h07FF);
        end
        default: begin
          write_register(CFG_ALPHA, ALPHA_W'($urandom_range(0, 65535)));
          write_register(CFG_HALF, ALPHA_W'($urandom_range(0, 2047)));
        end
      endcase
      for (int k = 0; k < per_phase; k++)
        send_index(pick_index(), 1'b1);
      // sender pauses for a full drain between phases
      drain();
    end
  endtask

  initial begin
    fail_count   = 0;
    hold_request = 1'b0;
    hold_active  = 1'b0;
    shadow_alpha = 16'd8192;
    shadow_half  = 11'd64;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_ALPHA;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    index     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_extremes();
    test_backpressure_fill();
    test_random_phases(1880);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
